// ===== rtl/pre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants
// Sizes, policy codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package pre_pkg;
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int AGE_BITS  = 16;
    localparam int FIDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS  = $clog2(FRAMES + 1);

    localparam logic [1:0] POL_LRU   = 2'd0;
    localparam logic [1:0] POL_FIFO  = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_COMMIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic sweep;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic has_empty;
        logic sweep_done;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/pre_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pre_ctrl: reference sequencer
// Steps one reference through lookup, optional clock sweep, commit, output.
// ----------------------------------------------------------------------------
module pre_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    input  wire             i_out_ready,
    input  wire [1:0]       i_policy,
    input  pre_pkg::t_status i_status,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output pre_pkg::t_cmd   o_cmd
);
    pre_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pre_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pre_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = pre_pkg::ST_LOOKUP;
            end
            pre_pkg::ST_LOOKUP: begin
                if (!i_status.hit && !i_status.has_empty && i_policy == pre_pkg::POL_CLOCK)
                    n_state = pre_pkg::ST_SWEEP;
                else
                    n_state = pre_pkg::ST_COMMIT;
            end
            pre_pkg::ST_SWEEP: begin
                if (i_status.sweep_done) n_state = pre_pkg::ST_COMMIT;
            end
            pre_pkg::ST_COMMIT: n_state = pre_pkg::ST_OUT;
            pre_pkg::ST_OUT: begin
                // result register is free once taken; accept next beat right away
                if (i_out_ready) n_state = i_in_valid ? pre_pkg::ST_LOOKUP : pre_pkg::ST_IDLE;
            end
            default: n_state = pre_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pre_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            pre_pkg::ST_LOOKUP: o_cmd.lookup = 1'b1;
            pre_pkg::ST_SWEEP:  o_cmd.sweep  = 1'b1;
            pre_pkg::ST_COMMIT: o_cmd.commit = 1'b1;
            pre_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                o_cmd.load  = i_out_ready && i_in_valid;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/pre_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pre_dp: frame table datapath
// Tags, valid bits, ages, reference bits, pointers and the result register.
// ----------------------------------------------------------------------------
module pre_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [4:0]                    i_cfg_data,
    input  wire [pre_pkg::PAGE_BITS-1:0] i_page,
    input  pre_pkg::t_cmd                i_cmd,
    output pre_pkg::t_status             o_status,
    output logic [1:0]                   o_policy,
    output logic [23:0]                  o_result
);
    localparam int FB = pre_pkg::FIDX_BITS;
    localparam int CB = pre_pkg::CNT_BITS;
    localparam logic [pre_pkg::AGE_BITS-1:0] AGE_MAX = '1;

    logic [pre_pkg::PAGE_BITS-1:0] r_tag [pre_pkg::FRAMES];
    logic [pre_pkg::FRAMES-1:0]    r_valid, r_refb;
    logic [pre_pkg::AGE_BITS-1:0]  r_age [pre_pkg::FRAMES];
    logic [FB-1:0]  r_fifo, r_hand, r_fr, r_h;
    logic [CB-1:0]  r_filled;
    logic [1:0]     r_policy;
    logic [4:0]     r_nfr;
    logic [pre_pkg::PAGE_BITS-1:0] r_page;
    logic           r_hit, r_empty;
    logic [FB-1:0]  r_n1;   // active frames minus one
    logic [23:0]    r_result;

    logic [CB-1:0] w_n;
    logic [FB-1:0] w_hit_fr, w_emp_fr, w_lru_fr;
    logic          w_hit, w_emp;
    logic [pre_pkg::AGE_BITS-1:0] w_tage [pre_pkg::FRAMES];
    logic [FB-1:0]                w_tidx [pre_pkg::FRAMES];
    logic [pre_pkg::FRAMES-1:0]   w_tok;

    assign w_n = (r_nfr == 5'd0) ? CB'(1) :
                 ({27'd0, r_nfr} > 32'(pre_pkg::FRAMES)) ? CB'(pre_pkg::FRAMES) : CB'(r_nfr);

    always_comb begin
        w_hit = 1'b0; w_hit_fr = '0;
        w_emp = 1'b0; w_emp_fr = '0;
        for (int i = 0; i < pre_pkg::FRAMES; i++) begin
            if (CB'(i) < w_n) begin
                if (r_valid[i] && r_tag[i] == r_page) begin
                    w_hit = 1'b1; w_hit_fr = FB'(i);
                end
            end
        end
        for (int i = pre_pkg::FRAMES - 1; i >= 0; i--) begin
            if (CB'(i) < w_n && !r_valid[i]) begin
                w_emp = 1'b1; w_emp_fr = FB'(i);
            end
        end
    end

    // oldest active frame by a compare tree; the upper half wins ties
    always_comb begin
        for (int i = 0; i < pre_pkg::FRAMES; i++) begin
            w_tage[i] = r_age[i];
            w_tidx[i] = FB'(i);
            w_tok[i]  = CB'(i) < w_n;
        end
        for (int s = 1; s < pre_pkg::FRAMES; s = s * 2) begin
            for (int i = 0; i + s < pre_pkg::FRAMES; i = i + 2 * s) begin
                if (w_tok[i+s] && (!w_tok[i] || w_tage[i+s] >= w_tage[i])) begin
                    w_tage[i] = w_tage[i+s];
                    w_tidx[i] = w_tidx[i+s];
                    w_tok[i]  = 1'b1;
                end
            end
        end
        w_lru_fr = w_tidx[0];
    end

    function automatic logic [FB-1:0] f_next(input logic [FB-1:0] i, input logic [FB-1:0] n1);
        f_next = (i >= n1) ? '0 : i + FB'(1);
    endfunction

    assign o_status.hit        = w_hit;
    assign o_status.has_empty  = w_emp;
    assign o_status.sweep_done = !r_refb[r_h];
    assign o_policy = r_policy;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_refb   <= '0;
            r_fifo   <= '0;
            r_hand   <= '0;
            r_filled <= '0;
            r_policy <= pre_pkg::POL_LRU;
            r_nfr    <= 5'd16;
            for (int i = 0; i < pre_pkg::FRAMES; i++) r_age[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pre_pkg::CFG_POLICY) r_policy <= i_cfg_data[1:0];
                else r_nfr <= i_cfg_data;
            end
            if (i_cmd.load) r_page <= i_page;
            if (i_cmd.lookup) begin
                r_n1    <= FB'(w_n - CB'(1));
                r_hit   <= w_hit;
                r_empty <= w_emp;
                r_h     <= ({{(32-FB){1'b0}}, r_hand} < 32'(w_n)) ? r_hand : '0;
                if (w_hit)      r_fr <= w_hit_fr;
                else if (w_emp) r_fr <= w_emp_fr;
                else if (r_policy == pre_pkg::POL_FIFO)
                    r_fr <= ({{(32-FB){1'b0}}, r_fifo} < 32'(w_n)) ? r_fifo : '0;
                else r_fr <= w_lru_fr;
            end
            if (i_cmd.sweep) begin
                // second chance: clear set bit and step; stop on a clear bit
                if (r_refb[r_h]) begin
                    r_refb[r_h] <= 1'b0;
                    r_h <= f_next(r_h, r_n1);
                end else begin
                    r_fr <= r_h;
                end
            end
            if (i_cmd.commit) begin
                r_result <= {1'b0,
                             (!r_hit && !r_empty) ? 16'(r_tag[r_fr]) : 16'd0,
                             !r_hit && !r_empty,
                             !r_hit && r_empty,
                             4'(r_fr),
                             r_hit};
                for (int i = 0; i < pre_pkg::FRAMES; i++) begin
                    if (FB'(i) == r_fr)
                        r_age[i] <= '0;
                    else if ({{(32-FB){1'b0}}, FB'(i)} <= {{(32-FB){1'b0}}, r_n1}
                             && r_valid[i] && r_age[i] != AGE_MAX)
                        r_age[i] <= r_age[i] + pre_pkg::AGE_BITS'(1);
                end
                r_refb[r_fr] <= 1'b1;
                if (!r_hit) begin
                    r_tag[r_fr] <= r_page;
                    if (r_empty) begin
                        r_valid[r_fr] <= 1'b1;
                        if (r_filled != CB'(pre_pkg::FRAMES)) r_filled <= r_filled + CB'(1);
                        r_hand <= f_next(r_fr, r_n1);
                    end else if (r_policy == pre_pkg::POL_FIFO) begin
                        r_fifo <= f_next(r_fr, r_n1);
                    end else if (r_policy == pre_pkg::POL_CLOCK) begin
                        r_hand <= f_next(r_fr, r_n1);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/page_replacement_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_replacement_engine: LRU / FIFO / CLOCK page replacement
// Fully associative frame table with selectable victim policy.
// ----------------------------------------------------------------------------
// One reference at a time. A reference passes from accept through lookup, commit and
// the output register; a CLOCK eviction adds a second-chance sweep over the frames
// before commit. The next beat is accepted in the cycle the result is taken.
module page_replacement_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [4:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] page
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata    // hit, frame[4:1], filled_empty, evicted_valid,
                                        // evicted_page[22:7], pad
);
    pre_pkg::t_cmd    w_cmd;
    pre_pkg::t_status w_status;
    logic [1:0]       w_policy;

    pre_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_policy(w_policy), .i_status(w_status),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(w_cmd)
    );

    pre_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_page(s_axis_tdata[pre_pkg::PAGE_BITS-1:0]), .i_cmd(w_cmd),
        .o_status(w_status), .o_policy(w_policy), .o_result(m_axis_tdata)
    );

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.sweep |-> !s_axis_tready) else $error("accept during sweep");
    a_commit_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> m_axis_tvalid) else $error("no result after commit");
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[5] && !m_axis_tdata[6])
        else $error("hit with fill or eviction");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: page replacement engine testbench
// Drives page references under LRU, FIFO and CLOCK at several frame counts,
// predicts each result with a behavioral table model and checks every field.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int IDLE_TAIL = 60;
    localparam int WDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    page_replacement_engine i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct packed {
        logic        hit;
        logic [3:0]  frame;
        logic        filled_empty;
        logic        evicted_valid;
        logic [15:0] evicted_page;
    } t_access;

    // model state
    logic [15:0] mdl_page  [pre_pkg::FRAMES];
    logic        mdl_valid [pre_pkg::FRAMES];
    logic [15:0] mdl_age   [pre_pkg::FRAMES];
    logic        mdl_ref   [pre_pkg::FRAMES];
    int          mdl_fifo_ptr, mdl_hand;
    logic [1:0]  mdl_policy;
    logic [4:0]  mdl_frames;

    t_access     pending_q[$];
    int          n_errors = 0, n_checked = 0, n_sent = 0, n_hits = 0, n_evicts = 0;
    bit          quiet = 1'b0;      // no idling in the last part
    bit          stall_en = 1'b1;

    function automatic int next_frame(int i, int n);
        return (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function automatic t_access predict_access(logic [15:0] pg);
        t_access r;
        int n, fr, k;
        bit found;
        r = '0;
        fr = 0;
        n = (mdl_frames == 0) ? 1 :
            (mdl_frames > pre_pkg::FRAMES ? pre_pkg::FRAMES : mdl_frames);
        for (int i = 0; i < n; i++)
            if (mdl_valid[i] && mdl_page[i] == pg) begin
                r.hit = 1'b1;
                fr = i;
            end
        if (!r.hit) begin
            found = 1'b0;
            for (int i = 0; i < n; i++)
                if (!found && !mdl_valid[i]) begin
                    fr = i;
                    found = 1'b1;
                end
            if (found) begin
                r.filled_empty = 1'b1;
                mdl_valid[fr] = 1'b1;
                mdl_hand = next_frame(fr, n);
            end else begin
                if (mdl_policy == pre_pkg::POL_FIFO) begin
                    fr = (mdl_fifo_ptr < n) ? mdl_fifo_ptr : 0;
                    mdl_fifo_ptr = next_frame(fr, n);
                end else if (mdl_policy == pre_pkg::POL_CLOCK) begin
                    fr = (mdl_hand < n) ? mdl_hand : 0;
                    for (k = 0; k < 2 * n + 1; k++) begin
                        if (!mdl_ref[fr]) break;
                        mdl_ref[fr] = 1'b0;
                        fr = next_frame(fr, n);
                    end
                    mdl_hand = next_frame(fr, n);
                end else begin
                    fr = 0;
                    for (int i = 0; i < n; i++)
                        if (mdl_age[i] >= mdl_age[fr]) fr = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = mdl_page[fr];
            end
            mdl_page[fr] = pg;
        end
        for (int i = 0; i < n; i++)
            if (mdl_valid[i] && mdl_age[i] != 16'hFFFF) mdl_age[i]++;
        mdl_age[fr] = '0;
        mdl_ref[fr] = 1'b1;
        r.frame = fr[3:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp);
        n_errors++;
        $display("t=%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit           = m_axis_tdata[0];
            got.frame         = m_axis_tdata[4:1];
            got.filled_empty  = m_axis_tdata[5];
            got.evicted_valid = m_axis_tdata[6];
            got.evicted_page  = m_axis_tdata[22:7];
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 0);
            end else begin
                want = pending_q.pop_front();
                n_checked++;
                if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
                if (got.frame != want.frame) report_mismatch("frame", got.frame, want.frame);
                if (got.filled_empty != want.filled_empty)
                    report_mismatch("filled_empty", got.filled_empty, want.filled_empty);
                if (got.evicted_valid != want.evicted_valid)
                    report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
                if (got.evicted_page != want.evicted_page)
                    report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && stall_en && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (++idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [4:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pre_pkg::CFG_POLICY) mdl_policy = val[1:0];
        else mdl_frames = val;
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    // tvalid stays up after an accept so beats can follow back to back
    task automatic send_page(logic [15:0] pg, bit gaps);
        if (gaps && !quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pg;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q = {pending_q, predict_access(pg)};
        n_sent++;
    endtask

    // directed table: page and, where obvious, the expected beat
    typedef struct {
        logic [15:0] pg;
        bit          known;
        t_access     res;
    } t_vector;

    t_vector directed[] = '{
        '{16'h0000, 1, '{1'b0, 4'd0, 1'b1, 1'b0, 16'h0000}},
        '{16'hFFFF, 1, '{1'b0, 4'd1, 1'b1, 1'b0, 16'h0000}},
        '{16'h0000, 1, '{1'b1, 4'd0, 1'b0, 1'b0, 16'h0000}},
        '{16'hFFFF, 1, '{1'b1, 4'd1, 1'b0, 1'b0, 16'h0000}},
        '{16'h5555, 1, '{1'b0, 4'd2, 1'b1, 1'b0, 16'h0000}},
        '{16'hAAAA, 0, '0}, '{16'h1234, 0, '0}, '{16'h8001, 0, '0},
        '{16'h5555, 0, '0}, '{16'h7FFE, 0, '0}, '{16'h0001, 0, '0},
        '{16'h0000, 0, '0}
    };

    function automatic logic [15:0] pick_page(int span);
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(16'h3C00 + $urandom_range(0, span));
    endfunction

    initial begin
        t_access want;
        int pol_seq[] = '{0, 1, 2, 3, 2, 1, 0, 2};
        int frm_seq[] = '{16, 1, 3, 0, 31, 5, 8, 2};
        int span;
        foreach (mdl_valid[i]) begin
            mdl_valid[i] = 0; mdl_age[i] = 0; mdl_ref[i] = 0; mdl_page[i] = 0;
        end
        mdl_fifo_ptr = 0; mdl_hand = 0; mdl_policy = pre_pkg::POL_LRU; mdl_frames = 5'd16;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats, typed expectations are checked against the model prediction
        foreach (directed[i]) begin
            send_page(directed[i].pg, 1'b0);
            if (directed[i].known) begin
                want = pending_q[$];
                if (want != directed[i].res) report_mismatch("directed row", i, 0);
            end
        end
        // fill all 16 frames then evict under each policy
        for (int p = 0; p < 3; p++) begin
            drain_pipe();
            write_reg(pre_pkg::CFG_POLICY, 5'(p));
            for (int i = 0; i < 20; i++) send_page(16'hF000 + 16'($urandom_range(0, 22)), 1'b1);
        end

        // random phases over policy / frame-count settings
        foreach (pol_seq[ph]) begin
            drain_pipe();
            write_reg(pre_pkg::CFG_POLICY, 5'(pol_seq[ph]));
            write_reg(pre_pkg::CFG_FRAMES, 5'(frm_seq[ph]));
            span = (frm_seq[ph] == 0 ? 1 : (frm_seq[ph] > 16 ? 16 : frm_seq[ph])) + 3;
            if (ph == 4) stall_en = 1'b0;
            if (ph == 5) stall_en = 1'b1;
            if (ph == 7) quiet = 1'b1;
            for (int i = 0; i < 85; i++) begin
                send_page(pick_page(span), 1'b1);
                // sender holds off until the pipe is empty
                if (i == 40) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        drain_pipe();
        foreach (pending_q[i]) ;
        $display("sent %0d page references over LRU/FIFO/CLOCK and 1..16 frames,",
                 n_sent);
        $display("checked %0d results; %0d errors", n_checked, n_errors);
        if (n_errors == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pre_pkg.sv
rtl/pre_ctrl.sv
rtl/pre_dp.sv
rtl/page_replacement_engine.sv
sim/tb_top.sv
